// ===== src/msvae_pkg.sv =====
// shared types, widths and constants of the mean sample value auto exposure block
package msvae_pkg;

    // bin counter width, fraction width and the widths that follow from them
    localparam int COUNT_WIDTH = 23;
    localparam int TOT_W       = COUNT_WIDTH + 2;
    localparam int TOP_W       = COUNT_WIDTH + 4;
    localparam int FRAC_W      = 8;
    localparam int DIVD_W      = TOP_W + FRAC_W;

    // field and register widths
    localparam int LUMA_W   = 8;
    localparam int MSV_W    = 11;
    localparam int GAIN_W   = 10;
    localparam int BRIGHT_W = 16;
    localparam int ERR_W    = MSV_W + 1;
    localparam int PROD_W   = MSV_W + GAIN_W;
    localparam int STEP_W   = PROD_W - FRAC_W;
    localparam int SUM_W    = BRIGHT_W + 2;
    localparam int IDX_W    = $clog2(MSV_W);
    localparam int NUM_BINS = 4;
    localparam int BIN_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = MSV_W;

    // reset values
    localparam logic [MSV_W-1:0]    TARGET_RESET = MSV_W'(640);
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(100);
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = BRIGHT_W'(20000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_MUL,
        ST_UPD
    } msvae_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic pix_ready;
        logic cnt_en;
        logic sum_load;
        logic div_step;
        logic mul_load;
        logic upd_load;
    } msvae_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_last;
        logic res_free;
    } msvae_sts_t;

endpackage

// ===== src/msvae_pix_if.sv =====
// pixel request channel: valid, ready and one luminance pixel
interface msvae_pix_if
    import msvae_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [LUMA_W-1:0] luma;
    logic              frame_end;

    modport source (output valid, output luma, output frame_end, input ready);
    modport sink   (input valid, input luma, input frame_end, output ready);
endinterface

// ===== src/msvae_res_if.sv =====
// result request channel: valid, ready, mean sample value and brightness
interface msvae_res_if
    import msvae_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MSV_W-1:0]    msv_value;
    logic [BRIGHT_W-1:0] brightness;

    modport source (output valid, output msv_value, output brightness, input ready);
    modport sink   (input valid, input msv_value, input brightness, output ready);
endinterface

// ===== src/msvae_ctrl.sv =====
// controller state machine of the auto exposure block
module msvae_ctrl
    import msvae_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_last,
    input  msvae_sts_t sts,
    output msvae_cmd_t cmd
);

    msvae_state_t state_reg;
    msvae_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_last)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (sts.res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.pix_ready = 1'b1;
                cmd.cnt_en    = in_valid;
            end
            ST_SUM:
            begin
                cmd.sum_load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
            end
            ST_UPD:
            begin
                cmd.upd_load = sts.res_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/msvae_dpath.sv =====
// datapath: bin counters, divider, gain multiplier, brightness and output register
module msvae_dpath
    import msvae_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [LUMA_W-1:0]    luma,
    input  msvae_cmd_t           cmd,
    output msvae_sts_t           sts,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    msvae_res_if.source          res
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] count_reg [NUM_BINS];
    logic [MSV_W-1:0]       target_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [BRIGHT_W-1:0]    bright_reg;
    logic [BRIGHT_W-1:0]    bright_next;
    logic [DIVD_W-1:0]      rem_reg;
    logic [TOT_W-1:0]       den_reg;
    logic [MSV_W-1:0]       quo_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic                   neg_reg;
    logic                   res_valid_reg;
    logic [MSV_W-1:0]       res_msv_reg;
    logic [BRIGHT_W-1:0]    res_bright_reg;

    logic [BIN_W-1:0]         bin;
    logic [TOP_W-1:0]         top_sum;
    logic [TOT_W-1:0]         total_sum;
    logic [DIVD_W-1:0]        trial;
    logic signed [ERR_W-1:0]  err;
    logic [MSV_W-1:0]         mag;
    logic [STEP_W-1:0]        step;
    logic signed [SUM_W-1:0]  step_s;
    logic signed [SUM_W-1:0]  new_sum;

    assign bin = luma[LUMA_W-1 -: BIN_W];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET: target_reg <= cfg_data[MSV_W-1:0];
                CFG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // saturating bin counters, cleared once the sums are taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                count_reg[b] <= '0;
            end
        end
        else if (cmd.sum_load)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                count_reg[b] <= '0;
            end
        end
        else if (cmd.cnt_en)
        begin
            for (int b = 0; b < NUM_BINS; b++)
            begin
                if (bin == BIN_W'(b) && count_reg[b] != COUNT_MAX)
                begin
                    count_reg[b] <= count_reg[b] + 1'b1;
                end
            end
        end
    end

    // weighted sum and total of the four bins
    always_comb
    begin
        top_sum = TOP_W'(count_reg[0])
                + (TOP_W'(count_reg[1]) << 1)
                + TOP_W'(count_reg[2]) + (TOP_W'(count_reg[2]) << 1)
                + (TOP_W'(count_reg[3]) << 2);
        total_sum = TOT_W'(count_reg[0]) + TOT_W'(count_reg[1])
                  + TOT_W'(count_reg[2]) + TOT_W'(count_reg[3]);
    end

    // restoring divider, one quotient bit per cycle from the top
    assign trial = DIVD_W'(den_reg) << idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            rem_reg <= {top_sum, FRAC_W'(0)};
            den_reg <= total_sum;
            quo_reg <= '0;
            idx_reg <= IDX_W'(MSV_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg          <= rem_reg - trial;
                quo_reg[idx_reg] <= 1'b1;
            end
            idx_reg <= idx_reg - 1'b1;
        end
    end

    assign sts.div_last = (idx_reg == '0);

    // error magnitude times loop gain
    always_comb
    begin
        err = $signed({1'b0, target_reg}) - $signed({1'b0, quo_reg});
        mag = err[ERR_W-1] ? MSV_W'(-err) : err[MSV_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= PROD_W'(mag) * PROD_W'(gain_reg);
            neg_reg  <= err[ERR_W-1];
        end
    end

    // brightness update with clamping
    always_comb
    begin
        step    = prod_reg[PROD_W-1:FRAC_W];
        step_s  = $signed(SUM_W'(step));
        new_sum = $signed(SUM_W'(bright_reg)) + (neg_reg ? -step_s : step_s);
        if (new_sum < 0)
        begin
            bright_next = '0;
        end
        else if (new_sum > $signed(SUM_W'({BRIGHT_W{1'b1}})))
        begin
            bright_next = {BRIGHT_W{1'b1}};
        end
        else
        begin
            bright_next = new_sum[BRIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg <= BRIGHT_RESET;
        end
        else if (cmd.upd_load)
        begin
            bright_reg <= bright_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.upd_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd_load)
        begin
            res_msv_reg    <= quo_reg;
            res_bright_reg <= bright_next;
        end
    end

    assign sts.res_free   = !res_valid_reg || res.ready;
    assign res.valid      = res_valid_reg;
    assign res.msv_value  = res_msv_reg;
    assign res.brightness = res_bright_reg;

endmodule

// ===== src/msv_auto_exposure_top.sv =====
// Mean sample value auto exposure, top level.
// Input channel pix carries one luminance pixel per request; frame_end marks
// the frame's last pixel. Each pixel's top two bits pick one of four
// saturating quarter bins. Ordinary pixels are taken one per cycle while no
// frame end is in work. On a frame_end pixel the bins are summed, the mean
// sample value (Q3.8) is formed by a restoring divider at one quotient bit
// per cycle, the error to target_msv is scaled by loop_gain and added to the
// clamped brightness. The result request is registered and appears on res
// after the update state. pix.ready is low after the frame_end pixel is
// taken, through the sum, divide, multiply and update states.
// The result sits in an output register, so new pixels are taken while it
// waits; if a later frame finishes before res.ready takes the earlier result,
// the update holds until the register frees.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 target_msv,
// 1 loop_gain); user writes only while no frame end is in work; not enforced.
// Reset: bins cleared, brightness 20000, target 640, gain 100, no result.
module msv_auto_exposure_top
    import msvae_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    msvae_pix_if.sink            pix,
    msvae_res_if.source          res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    msvae_cmd_t cmd;
    msvae_sts_t sts;

    // controller
    msvae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix.valid),
        .in_last  (pix.frame_end),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    msvae_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .luma      (pix.luma),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    assign pix.ready = cmd.pix_ready;

endmodule

// ===== src/msvae_checker.sv =====
// port-level checker for the auto exposure top level, with its bind
module msvae_checker
    import msvae_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                pix_valid,
    input logic                pix_ready,
    input logic                pix_frame_end,
    input logic                res_valid,
    input logic                res_ready,
    input logic [MSV_W-1:0]    res_msv,
    input logic [BRIGHT_W-1:0] res_bright
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_msv) && $stable(res_bright))
        else $error("stalled result changed");

    // mean sample value stays within one to four
    a_msv_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_msv >= MSV_W'(256) && res_msv <= MSV_W'(1024))
        else $error("mean sample value out of range");

    // a frame end request starts the computation and stops intake
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && pix_frame_end |=> !pix_ready)
        else $error("pixel taken during frame end computation");

    // ordinary pixels stream without a gap
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && !pix_frame_end |=> pix_ready)
        else $error("intake stalled after ordinary pixel");

endmodule

bind msv_auto_exposure_top msvae_checker u_msvae_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pix_valid     (pix.valid),
    .pix_ready     (pix.ready),
    .pix_frame_end (pix.frame_end),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_msv       (res.msv_value),
    .res_bright    (res.brightness)
);
